>>> rtl/rrr_pkg.sv
// Shared widths, payload types and constants of the ray reflect/refract unit.
package rrr_pkg;

	localparam int VW      = 16;
	localparam int PR_W    = 32;
	localparam int D_W     = 33;
	localparam int M_W     = 49;
	localparam int REFL_W  = 23;
	localparam int RV_W    = 51;
	localparam int SV_W    = 50;
	localparam int S28_W   = 34;
	localparam int ETA_W   = 17;
	localparam int P_W     = 51;
	localparam int PERP_W  = 30;
	localparam int PP_W    = 60;
	localparam int LEN_W   = 57;
	localparam int ONE_SH  = 40;
	localparam int SQ_W    = 29;
	localparam int X_W     = 2 * SQ_W;
	localparam int REM_W   = SQ_W + 3;
	localparam int SN_W    = 46;
	localparam int FV_W    = 47;
	localparam int RES_W   = 27;
	localparam int FRAC_SH = 20;
	localparam int PIPE_DEPTH = 7 + SQ_W + 2;

	localparam logic CMD_REFLECT = 1'b0;
	localparam logic CMD_REFRACT = 1'b1;

	localparam logic signed [RES_W-1:0] SAT_MAX = RES_W'(32767);
	localparam logic signed [RES_W-1:0] SAT_MIN = -RES_W'(32768);

	typedef struct packed {
		logic                           cmd;
		logic [2:0][REFL_W-1:0]         refl;
		logic [2:0][PERP_W-1:0]         perp;
		logic [2:0][VW-1:0]             nrm;
	} side_t;

endpackage

>>> rtl/rrr_front.sv
// Front pipeline: dot product, reflection, perpendicular part and length error.
module rrr_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_valid,
	input  logic                         command,
	input  logic signed [rrr_pkg::VW-1:0] ray_x,
	input  logic signed [rrr_pkg::VW-1:0] ray_y,
	input  logic signed [rrr_pkg::VW-1:0] ray_z,
	input  logic signed [rrr_pkg::VW-1:0] normal_x,
	input  logic signed [rrr_pkg::VW-1:0] normal_y,
	input  logic signed [rrr_pkg::VW-1:0] normal_z,
	input  logic [rrr_pkg::VW-1:0]        eta_ratio,
	output logic                         valid,
	output logic [rrr_pkg::LEN_W-1:0]    diff,
	output rrr_pkg::side_t               side
);

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;

	logic cmd_s1, cmd_s2, cmd_s3, cmd_s4, cmd_s5, cmd_s6;
	logic signed [rrr_pkg::VW-1:0] r_s1 [3];
	logic signed [rrr_pkg::VW-1:0] r_s2 [3];
	logic signed [rrr_pkg::VW-1:0] r_s3 [3];
	logic signed [rrr_pkg::VW-1:0] n_s1 [3];
	logic signed [rrr_pkg::VW-1:0] n_s2 [3];
	logic signed [rrr_pkg::VW-1:0] n_s3 [3];
	logic signed [rrr_pkg::VW-1:0] n_s4 [3];
	logic signed [rrr_pkg::VW-1:0] n_s5 [3];
	logic signed [rrr_pkg::VW-1:0] n_s6 [3];
	logic [rrr_pkg::VW-1:0] eta_s1, eta_s2, eta_s3, eta_s4;
	logic signed [rrr_pkg::PR_W-1:0] pr_s1 [3];
	logic signed [rrr_pkg::D_W-1:0] d_s2;
	logic signed [rrr_pkg::M_W-1:0] m_s3 [3];
	logic signed [rrr_pkg::REFL_W-1:0] refl_s4 [3];
	logic signed [rrr_pkg::REFL_W-1:0] refl_s5 [3];
	logic signed [rrr_pkg::REFL_W-1:0] refl_s6 [3];
	logic signed [rrr_pkg::S28_W-1:0] s28_s4 [3];
	logic signed [rrr_pkg::P_W-1:0] p_s5 [3];
	logic signed [rrr_pkg::PERP_W-1:0] perp_s6 [3];
	logic [rrr_pkg::LEN_W-1:0] psq_s6 [3];
	logic [rrr_pkg::LEN_W-1:0] diff_s7;
	rrr_pkg::side_t side_s7;

	logic signed [rrr_pkg::VW-1:0] r_in [3];
	logic signed [rrr_pkg::VW-1:0] n_in [3];
	logic signed [rrr_pkg::RV_W-1:0] rv [3];
	logic signed [rrr_pkg::SV_W-1:0] sv [3];
	logic signed [rrr_pkg::PERP_W-1:0] perp_c [3];
	logic signed [rrr_pkg::PP_W-1:0] pp [3];
	logic [rrr_pkg::LEN_W-1:0] len_c, one_c;
	rrr_pkg::side_t side_c;

	assign r_in[0] = ray_x;
	assign r_in[1] = ray_y;
	assign r_in[2] = ray_z;
	assign n_in[0] = normal_x;
	assign n_in[1] = normal_y;
	assign n_in[2] = normal_z;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rv[i] = (rrr_pkg::RV_W'(r_s3[i]) <<< 28) - (rrr_pkg::RV_W'(m_s3[i]) <<< 1);
			sv[i] = (rrr_pkg::SV_W'(r_s3[i]) <<< 28) - rrr_pkg::SV_W'(m_s3[i]);
			perp_c[i] = p_s5[i][rrr_pkg::P_W-1:21];
			pp[i] = perp_c[i] * perp_c[i];
		end
		one_c = rrr_pkg::LEN_W'(1) << rrr_pkg::ONE_SH;
		len_c = psq_s6[0] + psq_s6[1] + psq_s6[2];
		side_c.cmd = cmd_s6;
		for (int i = 0; i < 3; i++) begin
			side_c.refl[i] = refl_s6[i];
			side_c.perp[i] = perp_s6[i];
			side_c.nrm[i]  = n_s6[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1 <= command;
			eta_s1 <= eta_ratio;
			for (int i = 0; i < 3; i++) begin
				r_s1[i]  <= r_in[i];
				n_s1[i]  <= n_in[i];
				pr_s1[i] <= r_in[i] * n_in[i];
			end

			cmd_s2 <= cmd_s1;
			eta_s2 <= eta_s1;
			d_s2 <= rrr_pkg::D_W'(pr_s1[0]) + rrr_pkg::D_W'(pr_s1[1])
				+ rrr_pkg::D_W'(pr_s1[2]);
			for (int i = 0; i < 3; i++) begin
				r_s2[i] <= r_s1[i];
				n_s2[i] <= n_s1[i];
			end

			cmd_s3 <= cmd_s2;
			eta_s3 <= eta_s2;
			for (int i = 0; i < 3; i++) begin
				r_s3[i] <= r_s2[i];
				n_s3[i] <= n_s2[i];
				m_s3[i] <= rrr_pkg::M_W'(d_s2) * rrr_pkg::M_W'(n_s2[i]);
			end

			cmd_s4 <= cmd_s3;
			eta_s4 <= eta_s3;
			for (int i = 0; i < 3; i++) begin
				n_s4[i]    <= n_s3[i];
				refl_s4[i] <= rv[i][rrr_pkg::RV_W-1:28];
				s28_s4[i]  <= sv[i][47:14];
			end

			cmd_s5 <= cmd_s4;
			for (int i = 0; i < 3; i++) begin
				n_s5[i]    <= n_s4[i];
				refl_s5[i] <= refl_s4[i];
				p_s5[i]    <= rrr_pkg::P_W'(s28_s4[i])
					* rrr_pkg::P_W'($signed({1'b0, eta_s4}));
			end

			cmd_s6 <= cmd_s5;
			for (int i = 0; i < 3; i++) begin
				n_s6[i]    <= n_s5[i];
				refl_s6[i] <= refl_s5[i];
				perp_s6[i] <= perp_c[i];
				psq_s6[i]  <= pp[i][rrr_pkg::LEN_W-1:0];
			end

			diff_s7 <= (len_c >= one_c) ? (len_c - one_c) : (one_c - len_c);
			side_s7 <= side_c;
		end
	end

	assign valid = vld_s7;
	assign diff  = diff_s7;
	assign side  = side_s7;

endmodule

>>> rtl/rrr_sqrt.sv
// Pipelined integer square root, one result bit per stage, with side payload.
module rrr_sqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic [rrr_pkg::LEN_W-1:0]     radicand,
	input  rrr_pkg::side_t                in_side,
	output logic                          valid,
	output logic [rrr_pkg::SQ_W-1:0]      root,
	output rrr_pkg::side_t                side
);

	localparam int N = rrr_pkg::SQ_W;

	logic                       vld_s  [N+1];
	logic [rrr_pkg::X_W-1:0]    x_s    [N+1];
	logic [rrr_pkg::REM_W-1:0]  rem_s  [N+1];
	logic [N-1:0]               root_s [N+1];
	rrr_pkg::side_t             side_s [N+1];

	assign vld_s[0]  = in_valid;
	assign x_s[0]    = rrr_pkg::X_W'(radicand);
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign side_s[0] = in_side;

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic [rrr_pkg::REM_W-1:0] rem_sh, trial, rem_nx;
		logic ge;

		always_comb begin
			rem_sh = {rem_s[k][rrr_pkg::REM_W-3:0], x_s[k][rrr_pkg::X_W-1 -: 2]};
			trial  = rrr_pkg::REM_W'({root_s[k], 2'b01});
			ge     = rem_sh >= trial;
			rem_nx = ge ? (rem_sh - trial) : rem_sh;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[k+1]    <= x_s[k] << 2;
				rem_s[k+1]  <= rem_nx;
				root_s[k+1] <= {root_s[k][N-2:0], ge};
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign valid = vld_s[N];
	assign root  = root_s[N];
	assign side  = side_s[N];

endmodule

>>> rtl/rrr_back.sv
// Back pipeline: refracted direction, command select, saturation and output register.
module rrr_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic [rrr_pkg::SQ_W-1:0]      root,
	input  rrr_pkg::side_t                in_side,
	output logic                          valid,
	output logic signed [rrr_pkg::VW-1:0] out_x,
	output logic signed [rrr_pkg::VW-1:0] out_y,
	output logic signed [rrr_pkg::VW-1:0] out_z,
	output logic                          saturated
);

	logic vld_s1, vld_s2;
	logic cmd_s1;
	logic signed [rrr_pkg::SN_W-1:0]   prod_s1 [3];
	logic signed [rrr_pkg::PERP_W-1:0] perp_s1 [3];
	logic signed [rrr_pkg::REFL_W-1:0] refl_s1 [3];
	logic signed [rrr_pkg::VW-1:0]     res_s2  [3];
	logic                              sat_s2;

	logic signed [rrr_pkg::FV_W-1:0]  fv  [3];
	logic signed [rrr_pkg::RES_W-1:0] sel [3];
	logic signed [rrr_pkg::VW-1:0]    clp [3];
	logic                             sat_c;

	always_comb begin
		sat_c = 1'b0;
		for (int i = 0; i < 3; i++) begin
			fv[i] = (rrr_pkg::FV_W'(perp_s1[i]) <<< 14) - rrr_pkg::FV_W'(prod_s1[i]);
			if (cmd_s1 == rrr_pkg::CMD_REFRACT) begin
				sel[i] = fv[i][rrr_pkg::FV_W-1:rrr_pkg::FRAC_SH];
			end else begin
				sel[i] = rrr_pkg::RES_W'(refl_s1[i]);
			end
			if (sel[i] > rrr_pkg::SAT_MAX) begin
				clp[i] = rrr_pkg::SAT_MAX[rrr_pkg::VW-1:0];
				sat_c  = 1'b1;
			end else if (sel[i] < rrr_pkg::SAT_MIN) begin
				clp[i] = rrr_pkg::SAT_MIN[rrr_pkg::VW-1:0];
				sat_c  = 1'b1;
			end else begin
				clp[i] = sel[i][rrr_pkg::VW-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1 <= in_side.cmd;
			for (int i = 0; i < 3; i++) begin
				perp_s1[i] <= in_side.perp[i];
				refl_s1[i] <= in_side.refl[i];
				prod_s1[i] <= rrr_pkg::SN_W'($signed({1'b0, root}))
					* rrr_pkg::SN_W'($signed(in_side.nrm[i]));
			end
			for (int i = 0; i < 3; i++) begin
				res_s2[i] <= clp[i];
			end
			sat_s2 <= sat_c;
		end
	end

	assign valid     = vld_s2;
	assign out_x     = res_s2[0];
	assign out_y     = res_s2[1];
	assign out_z     = res_s2[2];
	assign saturated = sat_s2;

endmodule

>>> rtl/ray_reflect_refract_unit.sv
// Top level of the ray reflect/refract unit: front, square root and back pipelines.
//
//   channel | direction | handshake              | payload
//   in      | input     | in_valid / in_ready    | command, ray_x/y/z, normal_x/y/z, eta_ratio
//   out     | output    | out_valid / out_ready  | out_x/y/z, saturated
//
// Accepts one item per cycle while the output register is empty or taken.
// Depth is set by the square root, 29 stages at one root bit each.
// All stages advance together whenever the output register is empty or taken.
// A stall holds every stage; nothing is dropped or repeated.
// Reset clears the valid bits only; the data registers are not reset.
module ray_reflect_refract_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          command,
	input  logic signed [rrr_pkg::VW-1:0] ray_x,
	input  logic signed [rrr_pkg::VW-1:0] ray_y,
	input  logic signed [rrr_pkg::VW-1:0] ray_z,
	input  logic signed [rrr_pkg::VW-1:0] normal_x,
	input  logic signed [rrr_pkg::VW-1:0] normal_y,
	input  logic signed [rrr_pkg::VW-1:0] normal_z,
	input  logic [rrr_pkg::VW-1:0]        eta_ratio,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [rrr_pkg::VW-1:0] out_x,
	output logic signed [rrr_pkg::VW-1:0] out_y,
	output logic signed [rrr_pkg::VW-1:0] out_z,
	output logic                          saturated
);

	logic en;
	logic fr_valid, sq_valid;
	logic [rrr_pkg::LEN_W-1:0] fr_diff;
	logic [rrr_pkg::SQ_W-1:0]  sq_root;
	rrr_pkg::side_t fr_side, sq_side;

	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	rrr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (in_valid),
		.command   (command),
		.ray_x     (ray_x),
		.ray_y     (ray_y),
		.ray_z     (ray_z),
		.normal_x  (normal_x),
		.normal_y  (normal_y),
		.normal_z  (normal_z),
		.eta_ratio (eta_ratio),
		.valid     (fr_valid),
		.diff      (fr_diff),
		.side      (fr_side)
	);

	rrr_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (fr_valid),
		.radicand (fr_diff),
		.in_side  (fr_side),
		.valid    (sq_valid),
		.root     (sq_root),
		.side     (sq_side)
	);

	rrr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sq_valid),
		.root      (sq_root),
		.in_side   (sq_side),
		.valid     (out_valid),
		.out_x     (out_x),
		.out_y     (out_y),
		.out_z     (out_z),
		.saturated (saturated)
	);

endmodule

>>> rtl/rrr_checker.sv
// Port-level checker for the ray reflect/refract unit, bound to the top level.
module rrr_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic signed [rrr_pkg::VW-1:0] out_x,
	input logic signed [rrr_pkg::VW-1:0] out_y,
	input logic signed [rrr_pkg::VW-1:0] out_z,
	input logic                          saturated
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y)
			&& $stable(out_z) && $stable(saturated))
		else $error("output item changed while stalled");

	a_stall_blocks_in: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while output stalled");

	a_empty_takes_in: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input refused with empty output");

	a_sat_at_rail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |-> out_x == 16'sh7FFF || out_x == -16'sh8000
			|| out_y == 16'sh7FFF || out_y == -16'sh8000
			|| out_z == 16'sh7FFF || out_z == -16'sh8000)
		else $error("saturated set with no component at a rail");

endmodule

bind ray_reflect_refract_unit rrr_checker u_rrr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_x     (out_x),
	.out_y     (out_y),
	.out_z     (out_z),
	.saturated (saturated)
);
